### hw/rtl/g2u_pkg.sv
// Shared types and constants for the GBK to UTF-8 transcoder.
package g2u_pkg;

  localparam int TABLE_DEPTH = 8192;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_LOW    = 8'hA1;
  localparam logic [7:0] LEAD_HIGH   = 8'hF7;
  localparam logic [7:0] TRAIL_HIGH  = 8'hFE;
  localparam logic [7:0] QMARK       = 8'h3F;
  localparam logic [7:0] CONT_MARK   = 8'h80;
  localparam logic [7:0] LEAD2_MARK  = 8'hC0;
  localparam logic [7:0] LEAD3_MARK  = 8'hE0;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [12:0] ROW_CELLS  = 13'd94;

  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_LOAD    = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_in;
    logic        last_in;
    logic [12:0] table_index;
    logic [15:0] table_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  typedef struct packed {
    logic       lookup;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } pend_t;

endpackage

### hw/rtl/g2u_emit.sv
// Output stage that forms UTF-8 bytes and sends them one word per cycle while dst_stall is low.
module g2u_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  g2u_pkg::pend_t     pend,
  input  logic [15:0]        cp,
  output logic               free,
  output logic               dst_valid,
  input  logic               dst_stall,
  output g2u_pkg::out_word_t dst_word
);

  logic       valid;
  logic [7:0] b0, b1, b2;
  logic [1:0] pos, last_pos;
  logic       last;
  logic [7:0] b0_next, b1_next, b2_next;
  logic [1:0] last_pos_next;
  logic       at_end;

  always_comb begin
    b0_next = pend.b0;
    b1_next = pend.b1;
    b2_next = g2u_pkg::QMARK;
    last_pos_next = {1'b0, pend.two};
    if (pend.lookup) begin
      if (cp == 16'd0) begin
        b0_next = g2u_pkg::QMARK;
        last_pos_next = 2'd0;
      end else if (cp < {8'd0, g2u_pkg::ASCII_LIMIT}) begin
        b0_next = cp[7:0];
        last_pos_next = 2'd0;
      end else if (cp < g2u_pkg::TWO_BYTE_LIMIT) begin
        b0_next = g2u_pkg::LEAD2_MARK | {3'd0, cp[10:6]};
        b1_next = g2u_pkg::CONT_MARK | {2'd0, cp[5:0]};
        last_pos_next = 2'd1;
      end else begin
        b0_next = g2u_pkg::LEAD3_MARK | {4'd0, cp[15:12]};
        b1_next = g2u_pkg::CONT_MARK | {2'd0, cp[11:6]};
        b2_next = g2u_pkg::CONT_MARK | {2'd0, cp[5:0]};
        last_pos_next = 2'd2;
      end
    end
  end

  assign at_end = (pos == last_pos);
  assign free = !valid || (!dst_stall && at_end);
  assign dst_valid = valid;

  always_comb begin
    unique case (pos)
      2'd0:    dst_word.byte_out = b0;
      2'd1:    dst_word.byte_out = b1;
      default: dst_word.byte_out = b2;
    endcase
    dst_word.run_last = at_end;
    dst_word.string_end = at_end && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos <= 2'd0;
    end else if (take) begin
      valid <= 1'b1;
      pos <= 2'd0;
    end else if (valid && !dst_stall) begin
      if (at_end) begin
        valid <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b0 <= b0_next;
      b1 <= b1_next;
      b2 <= b2_next;
      last_pos <= last_pos_next;
      last <= pend.last;
    end
  end

endmodule

### hw/rtl/gbk_to_utf8_transcoder_top.sv
// Top level of the GBK to UTF-8 transcoder with its code point table.
//
// A word is accepted whenever the decode stage can move on, so words may follow
// back to back; a table load word is written to the table memory in its accept
// cycle and gives no output. A byte pair reads the registered table memory and its
// code point is expanded in the output stage, which sends one UTF-8 byte per cycle
// while dst_stall is low: each output run is 1 to 3 bytes, set by the length of its
// UTF-8 sequence, and its first byte leaves from the output stage registers after
// the decode register. The table has no reset and must be loaded before it is used.
module gbk_to_utf8_transcoder_top #(
  parameter int TABLE_DEPTH = g2u_pkg::TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  g2u_pkg::in_word_t  src_word,
  output logic               dst_valid,
  input  logic               dst_stall,
  output g2u_pkg::out_word_t dst_word
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0]    map_table [TABLE_DEPTH];
  logic [15:0]    rd_data;
  logic           accept;
  logic           held;
  logic [7:0]     held_lead;
  logic           held_next;
  logic           s1_valid;
  g2u_pkg::pend_t s1, s1_next;
  logic           s1_load;
  logic           emit_free;
  logic           s1_move;
  logic [7:0]     b;
  logic           is_trail, is_lead, is_ascii;
  logic [12:0]    idx;
  logic           wr_en;

  assign b = src_word.byte_in;
  assign is_ascii = (b < g2u_pkg::ASCII_LIMIT);
  assign is_lead = (b >= g2u_pkg::LEAD_LOW) && (b <= g2u_pkg::LEAD_HIGH);
  assign is_trail = (b >= g2u_pkg::LEAD_LOW) && (b <= g2u_pkg::TRAIL_HIGH);
  assign idx = 13'(held_lead - g2u_pkg::LEAD_LOW) * g2u_pkg::ROW_CELLS
             + 13'(b - g2u_pkg::LEAD_LOW);

  assign s1_move = s1_valid && emit_free;
  assign src_stall = s1_valid && !emit_free;
  assign accept = src_valid && !src_stall;
  assign wr_en = accept && (src_word.mode == g2u_pkg::MODE_LOAD)
              && (32'(src_word.table_index) < TABLE_DEPTH);

  always_comb begin
    held_next = held;
    s1_load = 1'b0;
    s1_next.lookup = 1'b0;
    s1_next.two = 1'b0;
    s1_next.b0 = g2u_pkg::QMARK;
    s1_next.b1 = g2u_pkg::QMARK;
    s1_next.last = src_word.last_in;
    if (src_word.mode == g2u_pkg::MODE_CONVERT) begin
      held_next = 1'b0;
      s1_load = 1'b1;
      if (held && is_trail) begin
        s1_next.lookup = 1'b1;
      end else if (held) begin
        if (is_ascii) begin
          s1_next.two = 1'b1;
          s1_next.b1 = b;
        end else if (is_lead && !src_word.last_in) begin
          held_next = 1'b1;
        end else begin
          s1_next.two = 1'b1;
        end
      end else if (is_ascii) begin
        s1_next.b0 = b;
      end else if (is_lead && !src_word.last_in) begin
        held_next = 1'b1;
        s1_load = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      held_lead <= 8'd0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        held <= held_next;
        if (held_next && (src_word.mode == g2u_pkg::MODE_CONVERT)) begin
          held_lead <= b;
        end
        if (s1_load) begin
          s1_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s1_load) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_table[AW'(src_word.table_index)] <= src_word.table_value;
    end
    if (accept && s1_load && s1_next.lookup) begin
      rd_data <= map_table[AW'(idx)];
    end
  end

  g2u_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .take      (s1_move),
    .pend      (s1),
    .cp        (rd_data),
    .free      (emit_free),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule

### tb/tb_gbk_to_utf8_transcoder_top.sv
// Self-checking testbench for the GBK to UTF-8 transcoder with a random stall and gap handshake.
`timescale 1ns / 1ps

module tb_gbk_to_utf8_transcoder_top;

  localparam int RANDOM_WORDS = 150;
  localparam int LONG_HOLD    = 90;
  localparam int HOLD_AFTER   = 60;
  localparam int QUIET_TAIL   = 30;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                src_valid = 1'b0;
  logic                src_stall;
  g2u_pkg::in_word_t   src_word = '0;
  logic                dst_valid;
  logic                dst_stall = 1'b0;
  g2u_pkg::out_word_t  dst_word;

  g2u_pkg::in_word_t   pending[$];
  g2u_pkg::out_word_t  utf8_expect[$];

  // Predictor state.
  logic [15:0] code_table [g2u_pkg::TABLE_DEPTH];
  logic [7:0]  pred_lead;
  logic        pred_waiting;

  // Stimulus-side view of the lead byte and of the loaded table entries.
  bit          entry_loaded [g2u_pkg::TABLE_DEPTH];
  int          loaded_list[$];
  bit          gen_held;
  logic [7:0]  gen_lead;

  int          src_gap;
  int          stall_cnt;
  int          words_in;
  int          loads_in;
  int          bytes_out;
  int          mismatches;
  int          cycle_count;
  logic        quiet_phase;
  logic        holding_long;
  bit          hold_done;

  gbk_to_utf8_transcoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

  always #5 clk = ~clk;

  function automatic void emit_utf8(input logic [7:0] b);
    g2u_pkg::out_word_t w;
    w.byte_out = b;
    w.run_last = 1'b0;
    w.string_end = 1'b0;
    utf8_expect.push_back(w);
  endfunction

  function automatic void emit_code_point(input logic [15:0] cp);
    if (cp == 16'h0) begin
      emit_utf8(g2u_pkg::QMARK);
    end else if (cp < 16'h0080) begin
      emit_utf8(cp[7:0]);
    end else if (cp < g2u_pkg::TWO_BYTE_LIMIT) begin
      emit_utf8(g2u_pkg::LEAD2_MARK | {3'b000, cp[10:6]});
      emit_utf8(g2u_pkg::CONT_MARK | {2'b00, cp[5:0]});
    end else begin
      emit_utf8(g2u_pkg::LEAD3_MARK | {4'b0000, cp[15:12]});
      emit_utf8(g2u_pkg::CONT_MARK | {2'b00, cp[11:6]});
      emit_utf8(g2u_pkg::CONT_MARK | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void take_fresh(input logic [7:0] b, input logic last);
    if (b < g2u_pkg::ASCII_LIMIT) begin
      emit_utf8(b);
    end else if (b >= g2u_pkg::LEAD_LOW && b <= g2u_pkg::LEAD_HIGH && !last) begin
      pred_lead = b;
      pred_waiting = 1'b1;
    end else begin
      emit_utf8(g2u_pkg::QMARK);
    end
  endfunction

  function automatic void predict_utf8(input g2u_pkg::in_word_t w);
    int first;
    int idx;
    g2u_pkg::out_word_t tail;
    first = utf8_expect.size();
    if (w.mode == g2u_pkg::MODE_LOAD) begin
      if (int'(w.table_index) < g2u_pkg::TABLE_DEPTH) begin
        code_table[w.table_index] = w.table_value;
      end
      return;
    end
    if (pred_waiting) begin
      pred_waiting = 1'b0;
      if (w.byte_in >= g2u_pkg::LEAD_LOW && w.byte_in <= g2u_pkg::TRAIL_HIGH) begin
        idx = (int'(pred_lead) - int'(g2u_pkg::LEAD_LOW)) * int'(g2u_pkg::ROW_CELLS)
            + (int'(w.byte_in) - int'(g2u_pkg::LEAD_LOW));
        emit_code_point((idx < g2u_pkg::TABLE_DEPTH) ? code_table[idx] : 16'h0);
      end else begin
        emit_utf8(g2u_pkg::QMARK);
        take_fresh(w.byte_in, w.last_in);
      end
    end else begin
      take_fresh(w.byte_in, w.last_in);
    end
    if (utf8_expect.size() > first) begin
      tail = utf8_expect.pop_back();
      tail.run_last = 1'b1;
      tail.string_end = w.last_in;
      utf8_expect.push_back(tail);
    end
  endfunction

  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 4))
      0: return 16'h0;
      1: return 16'($urandom_range(1, 'h7F));
      2: return 16'($urandom_range('h80, 'h7FF));
      3: return 16'($urandom_range('h800, 'hFFFF));
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic void push_load(input int idx, input logic [15:0] cp);
    g2u_pkg::in_word_t w;
    w.mode = g2u_pkg::MODE_LOAD;
    w.byte_in = 8'($urandom);
    w.last_in = 1'($urandom);
    w.table_index = 13'(idx);
    w.table_value = cp;
    pending.push_back(w);
    if (!entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endfunction

  // A trail byte after a held lead always finds its table entry loaded.
  function automatic void push_byte(input logic [7:0] b, input logic last);
    g2u_pkg::in_word_t w;
    int idx;
    if (gen_held && b >= g2u_pkg::LEAD_LOW && b <= g2u_pkg::TRAIL_HIGH) begin
      idx = (int'(gen_lead) - int'(g2u_pkg::LEAD_LOW)) * int'(g2u_pkg::ROW_CELLS)
          + (int'(b) - int'(g2u_pkg::LEAD_LOW));
      if (!entry_loaded[idx]) push_load(idx, random_code_point());
      gen_held = 1'b0;
    end else begin
      gen_held = (b >= g2u_pkg::LEAD_LOW && b <= g2u_pkg::LEAD_HIGH && !last);
      gen_lead = b;
    end
    w.mode = g2u_pkg::MODE_CONVERT;
    w.byte_in = b;
    w.last_in = last;
    w.table_index = 13'($urandom);
    w.table_value = 16'($urandom);
    pending.push_back(w);
  endfunction

  function automatic void push_pair(input int idx, input logic last);
    push_byte(g2u_pkg::LEAD_LOW + 8'(idx / int'(g2u_pkg::ROW_CELLS)), 1'b0);
    push_byte(g2u_pkg::LEAD_LOW + 8'(idx % int'(g2u_pkg::ROW_CELLS)), last);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      src_gap <= 0;
      words_in <= 0;
      loads_in <= 0;
      quiet_phase <= 1'b0;
    end else begin
      if (src_valid && !src_stall) begin
        predict_utf8(src_word);
        words_in <= words_in + 1;
        if (src_word.mode == g2u_pkg::MODE_LOAD) loads_in <= loads_in + 1;
      end
      quiet_phase <= (pending.size() < QUIET_TAIL);
      if (src_valid && src_stall) begin
        src_valid <= 1'b1;
      end else if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        src_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        src_valid <= 1'b0;
      end else if (!quiet_phase && !holding_long && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 16);
        src_valid <= 1'b0;
      end else begin
        src_valid <= 1'b1;
        src_word <= pending.pop_front();
      end
    end
  end

  always @(posedge clk) begin : monitor
    g2u_pkg::out_word_t want;
    if (rst) begin
      dst_stall <= 1'b0;
      stall_cnt <= 0;
      holding_long <= 1'b0;
      hold_done <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) begin
        bytes_out++;
        if (utf8_expect.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: byte %02h run_last %0d string_end %0d",
                     dst_word.byte_out, dst_word.run_last, dst_word.string_end);
          mismatches++;
        end else begin
          want = utf8_expect.pop_front();
          if (dst_word.byte_out !== want.byte_out || dst_word.run_last !== want.run_last
              || dst_word.string_end !== want.string_end) begin
            if (mismatches < 10)
              $display("mismatch: expected byte %02h run_last %0d string_end %0d, %s %02h %0d %0d",
                       want.byte_out, want.run_last, want.string_end, "got",
                       dst_word.byte_out, dst_word.run_last, dst_word.string_end);
            mismatches++;
          end
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        dst_stall <= 1'b1;
      end else if (!hold_done && words_in >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        holding_long <= 1'b1;
        stall_cnt <= LONG_HOLD - 1;
        dst_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        holding_long <= 1'b0;
        stall_cnt <= $urandom_range(0, 16);
        dst_stall <= 1'b1;
      end else begin
        holding_long <= 1'b0;
        dst_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[gbk_to_utf8_transcoder_top] ERROR");
      $finish;
    end
  end

  initial begin
    int directed;
    int len;
    logic last;
    pred_waiting = 1'b0;
    pred_lead = '0;
    gen_held = 1'b0;
    gen_lead = '0;
    bytes_out = 0;
    mismatches = 0;
    cycle_count = 0;

    push_load(0, 16'h4E2D);
    push_load(8177, 16'hFFFF);
    push_load(8191, 16'h1234);
    push_load(1, 16'h0000);
    push_load(2, 16'h007F);
    push_load(3, 16'h0080);
    push_load(4, 16'h07FF);
    push_load(5, 16'h0800);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_pair(0, 1'b1);
    push_pair(8177, 1'b0);
    push_pair(1, 1'b0);
    push_pair(2, 1'b0);
    push_pair(3, 1'b0);
    push_pair(4, 1'b0);
    push_pair(5, 1'b1);
    push_byte(8'hA1, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hF7, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'hF8, 1'b1);
    directed = pending.size();

    // Mostly well-formed strings of ASCII and mapped pairs, with noise mixed in.
    while (pending.size() < directed + RANDOM_WORDS) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_byte(8'($urandom_range(0, 'h7F)), last);
          4, 5, 6: push_pair(loaded_list[$urandom_range(0, loaded_list.size() - 1)], last);
          7: push_pair($urandom_range(0, 8177), last);
          8: push_byte(8'($urandom_range(0, 255)), last);
          default: push_load($urandom_range(0, g2u_pkg::TABLE_DEPTH - 1),
                             random_code_point());
        endcase
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || src_valid) @(posedge clk);
    while (utf8_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d table loads), checked %0d UTF-8 bytes, %0d mismatches.",
             words_in, loads_in, bytes_out, mismatches);
    $display("Stimulus covered ASCII, mapped pairs of 1 to 3 bytes, bad trails and a long hold.");
    if (mismatches == 0 && utf8_expect.size() == 0) begin
      $display("[gbk_to_utf8_transcoder_top] OK");
    end else begin
      $display("[gbk_to_utf8_transcoder_top] ERROR");
    end
    $finish;
  end

endmodule
